FILE: hw/rtl/rrtg_pkg.sv
// Shared types, constants and codes for the RRT grid tree growth block.
package rrtg_pkg;

  localparam int unsigned GridSizeDef = 128;
  localparam int unsigned MaxNodesDef = 1024;
  localparam int unsigned CoordW      = 7;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_START  = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_WRITTEN   = 3'd0,
    ST_STARTED   = 3'd1,
    ST_ADDED     = 3'd2,
    ST_OCCUPIED  = 3'd3,
    ST_COLLISION = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [CoordW-1:0] point_x;
    logic [CoordW-1:0] point_y;
    logic              occupied;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [CoordW-1:0] parent_x;
    logic [CoordW-1:0] parent_y;
    logic [9:0]        node_index;
  } out_item_t;

endpackage

FILE: hw/rtl/rrtg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rrtg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/rrt_grid_tree_growth.sv
// Cell write, start, command three or refused sample: from acceptance through CHECK and FINISH to OUT.
// Sample: every node is read and compared, then the line walk tests each cell on a row or column,
// each tenth step on a diagonal after a 20-step shared compare-subtract divide, or the one cell if identical.
// One transaction at a time; in_ready is low until the result is taken.
// After reset a clearing pass writes all 2**(2*clog2(GRID_SIZE)) grid words free (16384 by default),
// with in_ready low; node count resets to zero.
module rrt_grid_tree_growth #(
  parameter int unsigned GRID_SIZE = rrtg_pkg::GridSizeDef,
  parameter int unsigned MAX_NODES = rrtg_pkg::MaxNodesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rrtg_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rrtg_pkg::out_item_t out_data
);
  import rrtg_pkg::*;

  localparam int unsigned GW   = $clog2(GRID_SIZE);
  localparam int unsigned GAW  = 2 * GW;
  localparam int unsigned GD   = 1 << GAW;
  localparam int unsigned NAW  = $clog2(MAX_NODES);
  localparam int unsigned NCW  = $clog2(MAX_NODES + 1);
  localparam int unsigned DW   = 2 * CoordW + 2;   // squared distance
  localparam int unsigned KW   = CoordW + 5;       // up to 10*127
  localparam int unsigned NUMW = 2 * CoordW + 6;   // ly*den + dy*k, magnitude

  localparam logic [1:0] LM_ROW  = 2'd0;
  localparam logic [1:0] LM_COL  = 2'd1;
  localparam logic [1:0] LM_DIAG = 2'd2;
  localparam logic [1:0] LM_SAME = 2'd3;

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_CHECK  = 10'b0000000100,
    S_NREAD  = 10'b0000001000,
    S_NCMP   = 10'b0000010000,
    S_LSETUP = 10'b0000100000,
    S_LREAD  = 10'b0001000000,
    S_LTEST  = 10'b0010000000,
    S_FINISH = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_e;

  state_e state_r, state_nxt;
  in_item_t item_r;
  out_item_t res_r;
  logic [GAW:0] clr_r;
  logic [NCW-1:0] cnt_r;
  logic [NCW-1:0] n_r;
  logic [DW-1:0] bestd_r;
  logic [CoordW-1:0] par_x_r, par_y_r;
  logic first_r;
  logic pass_r;
  // line walk registers
  logic [1:0] lmode_r;  // row, column, diagonal or identical points
  logic [CoordW-1:0] lx_r, ly_r, hi_r, i_r;
  logic [KW-1:0] k_r, den_r, kdiv_r;
  logic [3:0] ktenth_r;
  logic signed [CoordW:0] dy_r;
  logic signed [NUMW:0] num_r;
  logic [CoordW-1:0] cyq_r;
  logic [NUMW:0] rem_r;
  logic [4:0] div_step_r;
  logic in_div_r;

  // grid RAM
  logic g_we;
  logic [GAW-1:0] g_waddr, g_raddr;
  logic g_wdata, g_rdata;
  logic g_oob_r;
  rrtg_ram #(.Width(1), .Depth(GD)) u_grid (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata));

  // tree RAM
  logic t_we;
  logic [NAW-1:0] t_waddr, t_raddr;
  logic [2*CoordW-1:0] t_wdata, t_rdata;
  rrtg_ram #(.Width(2*CoordW), .Depth(MAX_NODES)) u_tree (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata));

  // cell address, out of grid flagged
  logic [CoordW-1:0] cx, cy;
  logic c_oob;
  always_comb begin
    c_oob   = ({{(32-CoordW){1'b0}}, cx} >= GRID_SIZE) ||
              ({{(32-CoordW){1'b0}}, cy} >= GRID_SIZE);
    g_raddr = GAW'({GW'(cx), GW'(cy)});
  end

  // squared distance from node to sample
  logic signed [CoordW:0] ddx, ddy;
  logic [DW-1:0] sq_dist;
  always_comb begin
    ddx     = $signed({1'b0, t_rdata[2*CoordW-1:CoordW]}) - $signed({1'b0, item_r.point_x});
    ddy     = $signed({1'b0, t_rdata[CoordW-1:0]}) - $signed({1'b0, item_r.point_y});
    sq_dist = DW'(ddx * ddx) + DW'(ddy * ddy);
  end

  // sample that cleared the line check and fits in the store
  logic line_ok, add_now;
  always_comb begin
    line_ok = pass_r && !(g_oob_r || g_rdata) && (lmode_r != LM_SAME);
    add_now = (state_r == S_FINISH) && (item_r.command == CMD_SAMPLE) &&
              (res_r.status == ST_WRITTEN) && line_ok && (cnt_r < NCW'(MAX_NODES));
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
    out_data  = res_r;
    g_we      = 1'b0;
    g_waddr   = GAW'({GW'(item_r.point_x), GW'(item_r.point_y)});
    g_wdata   = item_r.occupied;
    t_we      = 1'b0;
    t_waddr   = '0;
    t_wdata   = {item_r.point_x, item_r.point_y};
    t_raddr   = n_r[NAW-1:0];
    cx        = item_r.point_x;
    cy        = item_r.point_y;
    unique case (state_r)
      S_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_r[GAW-1:0];
        g_wdata = 1'b0;
        if (clr_r == (GAW+1)'(GD - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        // look up the incoming sample cell so CHECK sees it
        cx = in_data.point_x;
        cy = in_data.point_y;
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK:  state_nxt = S_FINISH;
      S_NREAD:  state_nxt = S_NCMP;
      S_NCMP:   state_nxt = (n_r + 1'b1 >= cnt_r) ? S_LSETUP : S_NREAD;
      S_LSETUP: state_nxt = S_LREAD;
      S_LREAD: begin
        if (lmode_r == LM_ROW) begin
          cx = i_r; cy = ly_r;
        end else if (lmode_r == LM_COL) begin
          cx = lx_r; cy = i_r;
        end else if (lmode_r == LM_DIAG) begin
          cx = lx_r + CoordW'(kdiv_r); cy = cyq_r;
        end
        if (!in_div_r) state_nxt = S_LTEST;
      end
      S_LTEST:  state_nxt = S_LREAD;
      S_FINISH: state_nxt = S_OUT;
      S_OUT:    if (out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
    if (add_now) begin
      t_we    = 1'b1;
      t_waddr = cnt_r[NAW-1:0];
    end
    if (state_r == S_CHECK && item_r.command == CMD_WRITE) begin
      g_we = !c_oob;
    end
    if (state_r == S_CHECK && item_r.command == CMD_START) begin
      t_we = 1'b1;
    end
    if (state_r == S_CHECK && item_r.command == CMD_SAMPLE && !(g_oob_r || g_rdata)
        && cnt_r != '0) state_nxt = S_NREAD;
    if (state_r == S_LTEST) begin
      if (g_oob_r || g_rdata || (lmode_r == LM_SAME)) state_nxt = S_FINISH;
      else if (lmode_r != LM_DIAG && i_r == hi_r) state_nxt = S_FINISH;
      else if (lmode_r == LM_DIAG && k_r + 1'b1 == den_r) state_nxt = S_FINISH;
    end
  end

  // CHECK uses the grid data of the sample cell read in IDLE->CHECK edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == S_CHECK && item_r.command == CMD_START) cnt_r <= NCW'(1);
      if (add_now) cnt_r <= cnt_r + 1'b1;
    end
    g_oob_r <= c_oob;
    unique case (state_r)
      S_IDLE: begin
        item_r <= in_data;
        res_r  <= '0;
      end
      S_CHECK: begin
        n_r     <= '0;
        first_r <= 1'b1;
        if (item_r.command == CMD_WRITE) res_r.status <= ST_WRITTEN;
        else if (item_r.command == CMD_START) res_r.status <= ST_STARTED;
        else if (item_r.command == CMD_SAMPLE) begin
          if (g_oob_r || g_rdata) res_r.status <= ST_OCCUPIED;
          else if (cnt_r == '0) res_r.status <= ST_COLLISION;
        end
      end
      S_NCMP: begin
        if (first_r || sq_dist < bestd_r) begin
          bestd_r <= sq_dist;
          par_x_r <= t_rdata[2*CoordW-1:CoordW];
          par_y_r <= t_rdata[CoordW-1:0];
        end
        first_r <= 1'b0;
        n_r     <= n_r + 1'b1;
      end
      S_LSETUP: begin
        res_r.parent_x <= par_x_r;
        res_r.parent_y <= par_y_r;
        k_r        <= '0;
        kdiv_r     <= '0;
        ktenth_r   <= '0;
        div_step_r <= '0;
        if (par_x_r == item_r.point_x && par_y_r == item_r.point_y) begin
          lmode_r  <= LM_SAME;
          pass_r   <= 1'b0;
          in_div_r <= 1'b0;
          ly_r     <= par_y_r;
          i_r      <= par_x_r;
        end else if (par_y_r == item_r.point_y) begin
          lmode_r  <= LM_ROW;
          pass_r   <= 1'b1;
          in_div_r <= 1'b0;
          ly_r     <= par_y_r;
          i_r      <= (par_x_r < item_r.point_x) ? par_x_r : item_r.point_x;
          hi_r     <= (par_x_r < item_r.point_x) ? item_r.point_x : par_x_r;
        end else if (par_x_r == item_r.point_x) begin
          lmode_r  <= LM_COL;
          pass_r   <= 1'b1;
          in_div_r <= 1'b0;
          lx_r     <= par_x_r;
          i_r      <= (par_y_r < item_r.point_y) ? par_y_r : item_r.point_y;
          hi_r     <= (par_y_r < item_r.point_y) ? item_r.point_y : par_y_r;
        end else begin
          lmode_r  <= LM_DIAG;
          pass_r   <= 1'b1;
          if (par_x_r < item_r.point_x) begin
            lx_r  <= par_x_r;
            ly_r  <= par_y_r;
            den_r <= KW'((item_r.point_x - par_x_r) * 4'd10);
            dy_r  <= $signed({1'b0, item_r.point_y}) - $signed({1'b0, par_y_r});
          end else begin
            lx_r  <= item_r.point_x;
            ly_r  <= item_r.point_y;
            den_r <= KW'((par_x_r - item_r.point_x) * 4'd10);
            dy_r  <= $signed({1'b0, par_y_r}) - $signed({1'b0, item_r.point_y});
          end
          in_div_r <= 1'b1;
          num_r    <= '0;
        end
      end
      S_LREAD: begin
        // diagonal: numerator ly*den + dy*k, then restoring divide by den
        if (lmode_r == LM_DIAG && in_div_r) begin
          if (div_step_r == 5'd0) begin
            rem_r      <= '0;
            cyq_r      <= '0;
            num_r      <= $signed((NUMW+1)'(ly_r * den_r)) +
                          $signed((NUMW+1)'(dy_r * $signed({1'b0, k_r})));
            div_step_r <= 5'd1;
          end else begin
            logic [NUMW+1:0] trial;
            // the sign bit of the numerator is zero, so walk the bits below it
            trial = {rem_r, num_r[NUMW - div_step_r]} - (NUMW+2)'(den_r);
            if (!trial[NUMW+1]) begin
              rem_r <= trial[NUMW:0];
              cyq_r <= {cyq_r[CoordW-2:0], 1'b1};
            end else begin
              rem_r <= {rem_r[NUMW-1:0], num_r[NUMW - div_step_r]};
              cyq_r <= {cyq_r[CoordW-2:0], 1'b0};
            end
            if (div_step_r == 5'(NUMW)) begin
              in_div_r   <= 1'b0;
              div_step_r <= 5'd0;
            end else begin
              div_step_r <= div_step_r + 1'b1;
            end
          end
        end
      end
      S_LTEST: begin
        if (g_oob_r || g_rdata || lmode_r == LM_SAME) pass_r <= 1'b0;
        i_r <= i_r + 1'b1;
        k_r <= k_r + 1'b1;
        in_div_r <= (lmode_r == LM_DIAG);
        if (ktenth_r == 4'd9) begin
          ktenth_r <= '0;
          kdiv_r   <= kdiv_r + 1'b1;
        end else begin
          ktenth_r <= ktenth_r + 1'b1;
        end
      end
      S_FINISH: begin
        if (item_r.command == CMD_SAMPLE && res_r.status == ST_WRITTEN) begin
          if (!line_ok) res_r.status <= ST_COLLISION;
          else if (!add_now) res_r.status <= ST_FULL;
          else begin
            res_r.status     <= ST_ADDED;
            res_r.node_index <= 10'(cnt_r);
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NCW'(MAX_NODES)) else $error("node count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
`endif
endmodule
